// ===== rtl/ntag_pkg.sv =====
// ============================================================================
// ntag_pkg
// Types and constants shared by the tensor transpose address generator.
// ============================================================================
package ntag_pkg;

    localparam int REG_AXES  = 4;
    localparam int SIZE_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RANK_W    = 3;
    localparam int ORDER_W   = 8;
    localparam int BYTES_W   = 5;
    localparam int IDX_W     = 33;
    localparam int ELEM_W    = 32;
    localparam int OFS_W     = 40;
    localparam int PROD_W    = IDX_W + SIZE_W;

    localparam logic [BYTES_W-1:0] MAX_BYTES = 5'd16;
    localparam logic [PROD_W-1:0]  MAX_COUNT = PROD_W'(64'h1_0000_0000);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_IDLE    = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK  = 3'd0,
        CFG_SIZE0 = 3'd1,
        CFG_SIZE1 = 3'd2,
        CFG_SIZE2 = 3'd3,
        CFG_SIZE3 = 3'd4,
        CFG_ORDER = 3'd5,
        CFG_BYTES = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [RANK_W-1:0]                rank;
        logic [REG_AXES-1:0][SIZE_W-1:0]  size;
        logic [ORDER_W-1:0]               axis_order;
        logic [BYTES_W-1:0]               element_bytes;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SETUP,
        S_SUM,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic mul;
        logic setup;
        logic sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic args_ok;
        logic active;
        logic k_zero;
        logic setup_ok;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/nd_transpose_address_generator.sv =====
// ============================================================================
// nd_transpose_address_generator
// Source and destination byte offset generator for a tensor transpose.
// ============================================================================
// The block walks the destination tensor in row-major order and returns one
// source and destination byte offset pair per transfer on the input channel.
// A restart item steps the multiplier once per axis and then the setup step,
// since the strides and the element count come out of one shared 33 by 16
// bit multiplier, one axis per cycle. A next-element item does the odometer
// step, the sum of the per-axis source partials, then scaling by the element
// size into the result register. An item that ends in idle status or fails
// the rank, element size or permutation check goes straight to the result
// register; a restart that ends in empty status or in an element count above
// two to the 32nd skips the sum. The write of the result waits while the
// previous result still waits on a stalled result channel. A new item is
// taken while the previous result still waits in the result register.
module nd_transpose_address_generator #(
    parameter int MAX_RANK = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ntag_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ntag_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_restart,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ntag_pkg::OFS_W-1:0]         o_read_offset,
    output logic [ntag_pkg::OFS_W-1:0]         o_dst_offset,
    output logic                               o_last,
    output logic [1:0]                         o_status
);

    ntag_pkg::t_cfg w_cfg;
    ntag_pkg::t_cmd w_cmd;
    ntag_pkg::t_sts w_sts;

    ntag_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ntag_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_restart (i_restart),
        .i_sts     (w_sts),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd)
    );

    ntag_dpath #(
        .MAX_RANK (MAX_RANK)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_restart     (i_restart),
        .i_stall       (i_stall),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_valid       (o_valid),
        .o_read_offset (o_read_offset),
        .o_dst_offset  (o_dst_offset),
        .o_last        (o_last),
        .o_status      (o_status)
    );

    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ntag_pkg::ST_OK)
        |-> o_last && (o_read_offset == '0) && (o_dst_offset == '0))
        else $error("Non-ok status result carries offsets or lacks last.");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Input taken again before the previous item finished.");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.take, w_cmd.mul, w_cmd.setup, w_cmd.sum, w_cmd.emit}))
        else $error("Controller issued more than one datapath command.");

endmodule

// ===== rtl/ntag_cfg.sv =====
// ============================================================================
// ntag_cfg
// Configuration register file written through a plain write port.
// ============================================================================
module ntag_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ntag_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ntag_pkg::CFG_W-1:0]        i_cfg_data,
    output ntag_pkg::t_cfg                    o_cfg
);

    ntag_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rank          <= ntag_pkg::RANK_W'(4);
            r_cfg.size          <= {ntag_pkg::REG_AXES{ntag_pkg::SIZE_W'(1)}};
            r_cfg.axis_order    <= ntag_pkg::ORDER_W'(228);
            r_cfg.element_bytes <= ntag_pkg::BYTES_W'(1);
        end else if (i_cfg_we) begin
            unique case (ntag_pkg::t_cfg_idx'(i_cfg_idx))
                ntag_pkg::CFG_RANK:  r_cfg.rank <= i_cfg_data[ntag_pkg::RANK_W-1:0];
                ntag_pkg::CFG_SIZE0: r_cfg.size[0] <= i_cfg_data;
                ntag_pkg::CFG_SIZE1: r_cfg.size[1] <= i_cfg_data;
                ntag_pkg::CFG_SIZE2: r_cfg.size[2] <= i_cfg_data;
                ntag_pkg::CFG_SIZE3: r_cfg.size[3] <= i_cfg_data;
                ntag_pkg::CFG_ORDER: r_cfg.axis_order <= i_cfg_data[ntag_pkg::ORDER_W-1:0];
                ntag_pkg::CFG_BYTES: begin
                    r_cfg.element_bytes <= i_cfg_data[ntag_pkg::BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/ntag_ctrl.sv =====
// ============================================================================
// ntag_ctrl
// Sequencer for argument checking, stride setup and offset emission.
// ============================================================================
module ntag_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_restart,
    input  ntag_pkg::t_sts  i_sts,
    output logic            o_stall,
    output ntag_pkg::t_cmd  o_cmd
);

    ntag_pkg::t_state r_state;
    ntag_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntag_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntag_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_restart) begin
                        n_state = i_sts.args_ok ? ntag_pkg::S_MUL : ntag_pkg::S_EMIT;
                    end else begin
                        n_state = i_sts.active ? ntag_pkg::S_SUM : ntag_pkg::S_EMIT;
                    end
                end
            end
            ntag_pkg::S_MUL: begin
                if (i_sts.k_zero) begin
                    n_state = ntag_pkg::S_SETUP;
                end
            end
            ntag_pkg::S_SETUP: begin
                n_state = i_sts.setup_ok ? ntag_pkg::S_SUM : ntag_pkg::S_EMIT;
            end
            ntag_pkg::S_SUM: begin
                n_state = ntag_pkg::S_EMIT;
            end
            ntag_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ntag_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ntag_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall     = (r_state != ntag_pkg::S_IDLE);
        o_cmd.take  = (r_state == ntag_pkg::S_IDLE) && i_valid;
        o_cmd.mul   = (r_state == ntag_pkg::S_MUL);
        o_cmd.setup = (r_state == ntag_pkg::S_SETUP);
        o_cmd.sum   = (r_state == ntag_pkg::S_SUM);
        o_cmd.emit  = (r_state == ntag_pkg::S_EMIT) && i_sts.out_free;
    end

endmodule

// ===== rtl/ntag_dpath.sv =====
// ============================================================================
// ntag_dpath
// Stride multiplier, destination odometer, offset scaling and result register.
// ============================================================================
module ntag_dpath #(
    parameter int MAX_RANK = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ntag_pkg::t_cfg                i_cfg,
    input  logic                          i_restart,
    input  logic                          i_stall,
    input  ntag_pkg::t_cmd                i_cmd,
    output ntag_pkg::t_sts                o_sts,
    output logic                          o_valid,
    output logic [ntag_pkg::OFS_W-1:0]    o_read_offset,
    output logic [ntag_pkg::OFS_W-1:0]    o_dst_offset,
    output logic                          o_last,
    output logic [1:0]                    o_status
);

    localparam int N_AXES = (MAX_RANK < ntag_pkg::REG_AXES) ? MAX_RANK : ntag_pkg::REG_AXES;
    localparam int AXW    = (N_AXES > 1) ? $clog2(N_AXES) : 1;
    localparam int SRCB_W = ntag_pkg::IDX_W + ntag_pkg::BYTES_W;
    localparam int DSTB_W = ntag_pkg::ELEM_W + ntag_pkg::BYTES_W;

    logic [ntag_pkg::SIZE_W-1:0]   w_size [N_AXES];
    logic [ntag_pkg::IDX_W-1:0]    r_stride [N_AXES];
    logic [ntag_pkg::SIZE_W-1:0]   r_extent [N_AXES];
    logic [ntag_pkg::SIZE_W-1:0]   r_cnt [N_AXES];
    logic [ntag_pkg::IDX_W-1:0]    r_part [N_AXES];
    logic                          w_inc [N_AXES];
    logic                          w_wrap [N_AXES];

    logic [ntag_pkg::IDX_W-1:0]    r_acc;
    logic                          r_ovf;
    logic [AXW-1:0]                r_k;
    logic [ntag_pkg::IDX_W-1:0]    r_count;
    logic [ntag_pkg::ELEM_W-1:0]   r_elem;
    logic [ntag_pkg::RANK_W-1:0]   r_run_rank;
    logic [ntag_pkg::BYTES_W-1:0]  r_run_bytes;
    logic [ntag_pkg::IDX_W-1:0]    r_src_idx;
    logic                          r_active;
    ntag_pkg::t_status             r_status;

    logic                          r_out_valid;
    logic [ntag_pkg::OFS_W-1:0]    r_out_src;
    logic [ntag_pkg::OFS_W-1:0]    r_out_dst;
    logic                          r_out_last;
    ntag_pkg::t_status             r_out_status;

    logic [ntag_pkg::PROD_W-1:0]   w_prod;
    logic                          w_big;
    logic                          w_rank_ok;
    logic                          w_bytes_ok;
    logic                          w_perm_ok;
    logic                          w_args_ok;
    logic                          w_zero;
    logic                          w_last;
    logic                          w_out_free;
    logic [AXW-1:0]                w_top;
    logic [ntag_pkg::IDX_W-1:0]    w_sum;
    logic [SRCB_W-1:0]             w_src_bytes;
    logic [DSTB_W-1:0]             w_dst_bytes;

    always_comb begin
        for (int j = 0; j < N_AXES; j++) begin
            w_size[j] = i_cfg.size[j];
        end
    end

    always_comb begin
        logic [ntag_pkg::REG_AXES-1:0] seen;
        logic [1:0]                    field;
        seen      = '0;
        w_perm_ok = 1'b1;
        for (int j = 0; j < ntag_pkg::REG_AXES; j++) begin
            field = i_cfg.axis_order[2*j +: 2];
            if (ntag_pkg::RANK_W'(j) < i_cfg.rank) begin
                if (({1'b0, field} >= i_cfg.rank) || seen[field]) begin
                    w_perm_ok = 1'b0;
                end
                seen[field] = 1'b1;
            end
        end
    end

    assign w_rank_ok  = (i_cfg.rank != '0) && (i_cfg.rank <= ntag_pkg::RANK_W'(N_AXES));
    assign w_bytes_ok = (i_cfg.element_bytes != '0)
                        && (i_cfg.element_bytes <= ntag_pkg::MAX_BYTES);
    assign w_args_ok  = w_rank_ok && w_bytes_ok && w_perm_ok;

    always_comb begin
        w_zero = 1'b0;
        for (int j = 0; j < N_AXES; j++) begin
            if ((ntag_pkg::RANK_W'(j) < i_cfg.rank) && (w_size[j] == '0)) begin
                w_zero = 1'b1;
            end
        end
    end

    assign w_prod = ntag_pkg::PROD_W'(r_acc) * ntag_pkg::PROD_W'(w_size[r_k]);
    assign w_big  = (w_prod > ntag_pkg::MAX_COUNT);

    assign w_top = AXW'(r_run_rank - ntag_pkg::RANK_W'(1));

    always_comb begin
        logic carry;
        carry = 1'b0;
        for (int j = N_AXES - 1; j >= 0; j--) begin
            w_inc[j]  = (j == int'(w_top)) || ((j < int'(w_top)) && carry);
            w_wrap[j] = w_inc[j] && (j != 0)
                        && (({1'b0, r_cnt[j]} + 17'd1) >= {1'b0, r_extent[j]});
            carry     = w_wrap[j];
        end
    end

    always_comb begin
        w_sum = '0;
        for (int j = 0; j < N_AXES; j++) begin
            w_sum = w_sum + r_part[j];
        end
    end

    assign w_src_bytes = SRCB_W'(r_src_idx) * SRCB_W'(r_run_bytes);
    assign w_dst_bytes = DSTB_W'(r_elem) * DSTB_W'(r_run_bytes);
    assign w_last      = (({1'b0, r_elem} + ntag_pkg::IDX_W'(1)) == r_count);
    assign w_out_free  = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take && i_restart) begin
                r_active <= 1'b0;
            end
            if (i_cmd.setup && !w_zero && !r_ovf) begin
                r_active <= 1'b1;
            end
            if (i_cmd.emit) begin
                if ((r_status == ntag_pkg::ST_OK) && w_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            if (i_restart) begin
                r_acc <= ntag_pkg::IDX_W'(1);
                r_ovf <= 1'b0;
                r_k   <= AXW'(i_cfg.rank - ntag_pkg::RANK_W'(1));
                for (int j = 0; j < N_AXES; j++) begin
                    r_cnt[j]  <= '0;
                    r_part[j] <= '0;
                end
                if (!w_args_ok) begin
                    r_status <= ntag_pkg::ST_INVALID;
                end
            end else if (r_active) begin
                r_status <= ntag_pkg::ST_OK;
                r_elem   <= r_elem + ntag_pkg::ELEM_W'(1);
                for (int j = 0; j < N_AXES; j++) begin
                    if (w_wrap[j]) begin
                        r_cnt[j]  <= '0;
                        r_part[j] <= '0;
                    end else if (w_inc[j]) begin
                        r_cnt[j]  <= r_cnt[j] + ntag_pkg::SIZE_W'(1);
                        r_part[j] <= r_part[j] + r_stride[j];
                    end
                end
            end else begin
                r_status <= ntag_pkg::ST_IDLE;
            end
        end

        if (i_cmd.mul) begin
            for (int j = 0; j < N_AXES; j++) begin
                if (AXW'(i_cfg.axis_order[2*j +: 2]) == r_k) begin
                    r_stride[j] <= r_acc;
                    r_extent[j] <= w_size[r_k];
                end
            end
            r_acc <= w_prod[ntag_pkg::IDX_W-1:0];
            r_ovf <= r_ovf | w_big;
            r_k   <= r_k - AXW'(1);
        end

        if (i_cmd.setup) begin
            r_count     <= r_acc;
            r_elem      <= '0;
            r_run_rank  <= i_cfg.rank;
            r_run_bytes <= i_cfg.element_bytes;
            if (w_zero) begin
                r_status <= ntag_pkg::ST_EMPTY;
            end else if (r_ovf) begin
                r_status <= ntag_pkg::ST_INVALID;
            end else begin
                r_status <= ntag_pkg::ST_OK;
            end
        end

        if (i_cmd.sum) begin
            r_src_idx <= w_sum;
        end

        if (i_cmd.emit) begin
            r_out_status <= r_status;
            if (r_status == ntag_pkg::ST_OK) begin
                r_out_src  <= ntag_pkg::OFS_W'(w_src_bytes);
                r_out_dst  <= ntag_pkg::OFS_W'(w_dst_bytes);
                r_out_last <= w_last;
            end else begin
                r_out_src  <= '0;
                r_out_dst  <= '0;
                r_out_last <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.args_ok  = w_args_ok;
        o_sts.active   = r_active;
        o_sts.k_zero   = (r_k == '0);
        o_sts.setup_ok = !w_zero && !r_ovf;
        o_sts.out_free = w_out_free;
    end

    assign o_valid       = r_out_valid;
    assign o_read_offset = r_out_src;
    assign o_dst_offset  = r_out_dst;
    assign o_last        = r_out_last;
    assign o_status      = r_out_status;

endmodule
